/* hw/rtl/rbsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer span manager package
// Shared field width, request codes, the result beat layout and default sizing.
// ----------------------------------------------------------------------------
package rbsm_pkg;

    // Width of the count and multi-bit result fields and of the size write data.
    localparam int FIELD_W = 15;

    // Default largest buffer length in bytes.
    localparam int MAX_BUFFER_BYTES = 16384;

    // Size that the buffer takes out of reset, before any register write.
    localparam int RESET_BUFFER_BYTES = 16384;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_RESERVE = 2'd0,
        REQ_CONSUME = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    // One result beat.
    typedef struct packed {
        logic [FIELD_W-1:0] granted;
        logic [FIELD_W-1:0] offset;
        logic               error;
        logic [FIELD_W-1:0] pending;
    } t_result;

endpackage

/* hw/rtl/rbsm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request beat: type and byte count.
// ----------------------------------------------------------------------------
interface rbsm_req_if;
    import rbsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] count;

    modport source (output valid, output req_type, output count, input ready);
    modport sink   (input valid, input req_type, input count, output ready);
endinterface

/* hw/rtl/rbsm_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result beat of the span manager.
// ----------------------------------------------------------------------------
interface rbsm_rsp_if;
    import rbsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] granted;
    logic [FIELD_W-1:0] offset;
    logic               error;
    logic [FIELD_W-1:0] pending;

    modport source (output valid, output granted, output offset, output error,
                    output pending, input ready);
    modport sink   (input valid, input granted, input offset, input error,
                    input pending, output ready);
endinterface

/* hw/rtl/rbsm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span manager core
// Holds the size, read index and write index registers and works out,
// combinationally, the result of one request and the next index values.
// ----------------------------------------------------------------------------
module rbsm_core #(
    parameter int MAX_BUFFER_BYTES = rbsm_pkg::MAX_BUFFER_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_req_type,
    input  logic [rbsm_pkg::FIELD_W-1:0]  i_count,
    input  logic                          i_cfg_we,
    input  logic [rbsm_pkg::FIELD_W-1:0]  i_cfg_wdata,
    output rbsm_pkg::t_result             o_result
);
    import rbsm_pkg::*;

    localparam int IDX_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int CW    = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;
    localparam int RST_SIZE = (MAX_BUFFER_BYTES < RESET_BUFFER_BYTES) ?
                              MAX_BUFFER_BYTES : RESET_BUFFER_BYTES;

    logic [IDX_W-1:0] r_size, r_rd, r_wr;
    logic [IDX_W-1:0] n_size, n_rd, n_wr;

    logic [CW-1:0] sz, rd, wr, cnt, cfg_v;
    logic [CW-1:0] rd_span, wr_span, wr_base, take, step_rd, step_wr;
    logic [CW-1:0] nrd, nwr, granted, offset, pending;
    logic          wrapped, wr_ok, error, n_wrapped;
    t_req          req;

    assign sz    = CW'(r_size);
    assign rd    = CW'(r_rd);
    assign wr    = CW'(r_wr);
    assign cnt   = CW'(i_count);
    assign cfg_v = CW'(i_cfg_wdata);
    assign req   = t_req'(i_req_type);

    // Readable contiguous span from the current indexes.
    assign wrapped = (wr < rd) || ((wr != '0) && (wr == rd));
    always_comb begin
        if (wrapped) begin
            rd_span = (sz > rd) ? (sz - rd) : '0;
        end else begin
            rd_span = wr - rd;
        end
    end

    // Writable contiguous span, folding the write index to the start
    // when it sits at the end and the reader has moved on.
    always_comb begin
        wr_ok   = 1'b1;
        wr_base = wr;
        wr_span = '0;
        if (wr < rd) begin
            wr_span = rd - wr;
        end else if ((rd != '0) && (wr == rd)) begin
            wr_ok = 1'b0;
        end else if (wr < sz) begin
            wr_span = sz - wr;
        end else if (rd == '0) begin
            wr_ok = 1'b0;
        end else begin
            wr_base = '0;
            wr_span = rd;
        end
    end

    // Request decode and next index values.
    always_comb begin
        nrd     = rd;
        nwr     = wr;
        granted = '0;
        offset  = '0;
        error   = 1'b0;
        take    = '0;
        step_rd = '0;
        step_wr = '0;
        case (req)
            REQ_RESERVE: begin
                offset = wr;
                if (cnt != '0) begin
                    if (wr_ok) begin
                        take    = (cnt < wr_span) ? cnt : wr_span;
                        offset  = wr_base;
                        step_wr = wr_base + take;
                        nwr     = ((step_wr == sz) && (rd != '0)) ? '0 : step_wr;
                        granted = take;
                    end else begin
                        error = 1'b1;
                    end
                end
            end
            REQ_CONSUME: begin
                offset = rd;
                if (cnt != '0) begin
                    if (rd_span == '0) begin
                        error = 1'b1;
                    end else begin
                        take    = (cnt < rd_span) ? cnt : rd_span;
                        step_rd = rd + take;
                        if (step_rd == sz) begin
                            nrd = '0;
                            if (wr == sz) begin
                                nwr = '0;
                            end
                        end else begin
                            nrd = step_rd;
                        end
                        // Reader caught up with the writer: drain to the start.
                        if (nrd == nwr) begin
                            nrd = '0;
                            nwr = '0;
                        end
                        granted = take;
                    end
                end
            end
            REQ_QUERY: begin
                offset  = rd;
                granted = rd_span;
            end
            REQ_CLEAR: begin
                nrd = '0;
                nwr = '0;
            end
            default: begin
                nrd = rd;
                nwr = wr;
            end
        endcase
    end

    // Bytes stored once this request has taken effect.
    assign n_wrapped = (nwr < nrd) || ((nwr != '0) && (nwr == nrd));
    assign pending   = n_wrapped ? (sz - (nrd - nwr)) : (nwr - nrd);

    assign o_result.granted = granted[FIELD_W-1:0];
    assign o_result.offset  = offset[FIELD_W-1:0];
    assign o_result.error   = error;
    assign o_result.pending = pending[FIELD_W-1:0];

    // Register updates: a size write clamps the value and clears both indexes.
    always_comb begin
        n_size = r_size;
        n_rd   = r_rd;
        n_wr   = r_wr;
        if (i_cfg_we) begin
            if (cfg_v == '0) begin
                n_size = IDX_W'(1);
            end else if (cfg_v > CW'(MAX_BUFFER_BYTES)) begin
                n_size = IDX_W'(MAX_BUFFER_BYTES);
            end else begin
                n_size = cfg_v[IDX_W-1:0];
            end
            n_rd = '0;
            n_wr = '0;
        end else if (i_accept) begin
            n_rd = nrd[IDX_W-1:0];
            n_wr = nwr[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= IDX_W'(RST_SIZE);
            r_rd   <= '0;
            r_wr   <= '0;
        end else begin
            r_size <= n_size;
            r_rd   <= n_rd;
            r_wr   <= n_wr;
        end
    end

endmodule

/* hw/rtl/ring_buffer_span_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer span manager
// Tracks the read and write indexes of a byte ring buffer and grants
// contiguous write and read spans on request.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock unless the request side stalls,
// and returns exactly one result beat for it, presented in the cycle after
// acceptance when the output register is free or being emptied, else held in
// a second entry behind it until the result side takes the output. All work
// for a request is a single pass through the index compare and add logic of
// the core, which updates the index registers at the accepting edge and loads
// the result into the output register or the second entry. That entry lets
// the block accept a request while the previous result is still waiting, so
// the request side stalls only after two results are backed up. Writing the
// buffer size register clears both indexes; do so only with no request in flight.
// ----------------------------------------------------------------------------
module ring_buffer_span_manager #(
    parameter int MAX_BUFFER_BYTES = rbsm_pkg::MAX_BUFFER_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rbsm_req_if.sink                     i_req,
    rbsm_rsp_if.source                   o_rsp,
    input  logic                         i_cfg_we,
    input  logic [rbsm_pkg::FIELD_W-1:0] i_cfg_wdata
);
    import rbsm_pkg::*;

    t_result result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    accept, pop;

    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;
    assign pop         = r_out_valid && o_rsp.ready;

    rbsm_core #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req.req_type),
        .i_count     (i_req.count),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.granted = r_out.granted;
    assign o_rsp.offset  = r_out.offset;
    assign o_rsp.error   = r_out.error;
    assign o_rsp.pending = r_out.pending;

endmodule

/* hw/rtl/rbsm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span manager port checker
// Watches the request and response ports of the span manager over time.
// ----------------------------------------------------------------------------
module rbsm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [rbsm_pkg::FIELD_W-1:0] i_rsp_granted,
    input logic                         i_rsp_error
);
    import rbsm_pkg::*;

    // Nothing is presented in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // The request side stalls only while a result is held up.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_rsp_valid)
        else $error("request stalled with no result pending");

    // A request accepted into an empty output shows up next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && !i_rsp_valid) |=> i_rsp_valid)
        else $error("accepted request produced no result");

    // A refused request grants nothing.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_error) |-> (i_rsp_granted == '0))
        else $error("error result with nonzero grant");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_granted)))
        else $error("stalled result changed");

endmodule

bind ring_buffer_span_manager rbsm_checker u_rbsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_granted (o_rsp.granted),
    .i_rsp_error   (o_rsp.error)
);

/* tb/ring_buffer_span_manager_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer span manager testbench
// Drives request beats and checks every result beat against an in-bench
// model of the index logic. A directed opening walks the special cases. It is
// followed by random phases over several buffer sizes, with random idling on
// both channels and one long hold-off on the result side to back up the block.
// ----------------------------------------------------------------------------
module ring_buffer_span_manager_tb;
    import rbsm_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int unsigned HANG_LIMIT   = 500;
    // Cycles allowed after the last result before a size write or the verdict.
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned PHASES       = 16;
    localparam int unsigned PHASE_ITEMS  = 112;
    // Result-side hold-off that fills the block and stalls the request side.
    localparam int unsigned LONG_HOLD    = 60;
    localparam int unsigned HOLD_TRIGGER = 600;

    // Expected-result store with its own copy of the index state.
    class span_scoreboard;
        int unsigned buf_size;
        int unsigned rd_idx;
        int unsigned wr_idx;
        t_result     expected_results[$];
        int unsigned mismatches;

        function new();
            buf_size    = clamp_size(RESET_BUFFER_BYTES);
            rd_idx      = 0;
            wr_idx      = 0;
            mismatches  = 0;
        endfunction

        function int unsigned clamp_size(int unsigned value);
            if (value == 0) return 1;
            if (value > MAX_BUFFER_BYTES) return MAX_BUFFER_BYTES;
            return value;
        endfunction

        // A size write also clears both indexes.
        function void write_size(logic [FIELD_W-1:0] value);
            buf_size = clamp_size(value);
            rd_idx   = 0;
            wr_idx   = 0;
        endfunction

        // Full (equal, nonzero) or write behind read counts as wrapped.
        function bit is_wrapped();
            return (wr_idx < rd_idx) || (wr_idx > 0 && wr_idx == rd_idx);
        endfunction

        function int unsigned stored_bytes();
            if (is_wrapped()) return buf_size - rd_idx + wr_idx;
            return wr_idx - rd_idx;
        endfunction

        function int unsigned readable_bytes();
            if (is_wrapped()) return (buf_size > rd_idx) ? buf_size - rd_idx : 0;
            return wr_idx - rd_idx;
        endfunction

        // Works out the result of one accepted request and queues it.
        function void note_request(t_req kind, logic [FIELD_W-1:0] count);
            t_result     res;
            int unsigned span;
            bit          room;
            res = '0;
            case (kind)
                REQ_RESERVE: begin
                    res.offset = FIELD_W'(wr_idx);
                    if (count != 0) begin
                        room = 1'b1;
                        span = 0;
                        if (wr_idx < rd_idx) begin
                            span = rd_idx - wr_idx;
                        end else if (rd_idx > 0 && wr_idx == rd_idx) begin
                            room = 1'b0;
                        end else if (wr_idx < buf_size) begin
                            span = buf_size - wr_idx;
                        end else if (rd_idx == 0) begin
                            room = 1'b0;
                        end else begin
                            // Writer at the end folds back in front of the reader.
                            wr_idx = 0;
                            span   = rd_idx;
                        end
                        if (room) begin
                            if (count < span) span = count;
                            res.offset = FIELD_W'(wr_idx);
                            wr_idx += span;
                            if (wr_idx == buf_size && rd_idx > 0) wr_idx = 0;
                            res.granted = FIELD_W'(span);
                        end else begin
                            res.error = 1'b1;
                        end
                    end
                end
                REQ_CONSUME: begin
                    res.offset = FIELD_W'(rd_idx);
                    if (count != 0) begin
                        span = readable_bytes();
                        if (span == 0) begin
                            res.error = 1'b1;
                        end else begin
                            if (count < span) span = count;
                            rd_idx += span;
                            if (rd_idx == buf_size) begin
                                rd_idx = 0;
                                if (wr_idx == buf_size) wr_idx = 0;
                            end
                            // A drained buffer restarts at offset zero.
                            if (rd_idx == wr_idx) begin
                                rd_idx = 0;
                                wr_idx = 0;
                            end
                            res.granted = FIELD_W'(span);
                        end
                    end
                end
                REQ_QUERY: begin
                    res.offset  = FIELD_W'(rd_idx);
                    res.granted = FIELD_W'(readable_bytes());
                end
                default: begin
                    rd_idx = 0;
                    wr_idx = 0;
                end
            endcase
            res.pending = FIELD_W'(stored_bytes());
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s: expected %0d, actual %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        // Compares one accepted result beat with the oldest expectation.
        function void check_result(t_result got);
            t_result exp;
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding");
                mismatches++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("granted", exp.granted, got.granted);
            compare_field("offset", exp.offset, got.offset);
            compare_field("error", exp.error, got.error);
            compare_field("pending", exp.pending, got.pending);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [FIELD_W-1:0] i_cfg_wdata;

    rbsm_req_if req_ch ();
    rbsm_rsp_if rsp_ch ();

    span_scoreboard span_board = new();

    bit          quiet_tail;
    bit          long_hold_on;
    int unsigned requests_accepted;

    ring_buffer_span_manager i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one request beat, with an occasional idle burst before it.
    task automatic send_request(t_req kind, logic [FIELD_W-1:0] count);
        int unsigned gap;
        if (!quiet_tail && !long_hold_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.count    <= count;
        do @(posedge i_clk); while (!req_ch.ready);
        span_board.note_request(kind, count);
        requests_accepted++;
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic wait_for_drain();
        while (span_board.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_buffer_size(logic [FIELD_W-1:0] value);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        span_board.write_size(value);
    endtask

    // Result side: checks each beat and idles at random, with one long hold-off.
    initial begin : result_sink
        int unsigned hold_left;
        bit          long_hold_done;
        t_result     got;
        hold_left      = 0;
        long_hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.granted = rsp_ch.granted;
                got.offset  = rsp_ch.offset;
                got.error   = rsp_ch.error;
                got.pending = rsp_ch.pending;
                span_board.check_result(got);
            end
            if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0) begin
                    long_hold_on = 1'b0;
                    rsp_ch.ready <= 1'b1;
                end
            end else if (!long_hold_done && requests_accepted >= HOLD_TRIGGER &&
                         req_ch.valid) begin
                long_hold_done = 1'b1;
                long_hold_on   = 1'b1;
                hold_left      = LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(1, 3);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Hang detection: ends the run after too long without any accepted beat.
    initial begin : hang_watch
        int unsigned still_cycles;
        still_cycles = 0;
        while (still_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                still_cycles = 0;
            else
                still_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus.
    initial begin : stimulus
        logic [FIELD_W-1:0] phase_sizes[PHASES];
        t_req               kind;
        logic [FIELD_W-1:0] count;
        int unsigned        roll;

        quiet_tail        = 1'b0;
        long_hold_on      = 1'b0;
        requests_accepted = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_QUERY;
        req_ch.count    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk at the reset size: empty buffer, zero counts, filling
        // to the end with nothing read, fold-back of the writer, a full buffer,
        // over-range counts and draining back to zero.
        send_request(REQ_QUERY, 15'd0);
        send_request(REQ_CONSUME, 15'd0);
        send_request(REQ_CONSUME, 15'd5);
        send_request(REQ_RESERVE, 15'd0);
        send_request(REQ_RESERVE, 15'd16384);
        send_request(REQ_RESERVE, 15'd1);
        send_request(REQ_QUERY, 15'h7fff);
        send_request(REQ_CONSUME, 15'd100);
        send_request(REQ_RESERVE, 15'd50);
        send_request(REQ_RESERVE, 15'd60);
        send_request(REQ_RESERVE, 15'd1);
        send_request(REQ_QUERY, 15'd0);
        send_request(REQ_CONSUME, 15'h7fff);
        send_request(REQ_CONSUME, 15'd200);
        send_request(REQ_RESERVE, 15'd300);
        send_request(REQ_CLEAR, 15'h7fff);
        send_request(REQ_RESERVE, 15'h7fff);
        send_request(REQ_CONSUME, 15'd16383);
        send_request(REQ_CLEAR, 15'd0);
        send_request(REQ_QUERY, 15'd0);
        req_ch.valid <= 1'b0;

        // Buffer sizes per phase: the clamped extremes, tiny rings and a few
        // random ones.
        phase_sizes[0]  = 15'd0;
        phase_sizes[1]  = 15'd1;
        phase_sizes[2]  = 15'd2;
        phase_sizes[3]  = 15'd3;
        phase_sizes[4]  = 15'd16384;
        phase_sizes[5]  = 15'h7fff;
        phase_sizes[6]  = 15'd7;
        phase_sizes[7]  = 15'd100;
        phase_sizes[8]  = 15'd1000;
        phase_sizes[9]  = FIELD_W'($urandom_range(0, 32767));
        for (int p = 10; p < PHASES; p++)
            phase_sizes[p] = FIELD_W'($urandom_range(1, 64));

        // Random phases. Counts mostly fit the ring so that wraps and drains
        // happen often; the rest are zero, exact size or any 15-bit value.
        for (int p = 0; p < PHASES; p++) begin
            write_buffer_size(phase_sizes[p]);
            if (p == PHASES - 1) quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)      kind = REQ_RESERVE;
                else if (roll < 75) kind = REQ_CONSUME;
                else if (roll < 92) kind = REQ_QUERY;
                else                kind = REQ_CLEAR;
                roll = $urandom_range(0, 9);
                if (roll == 0)      count = '0;
                else if (roll == 1) count = FIELD_W'($urandom_range(0, 32767));
                else if (roll == 2) count = FIELD_W'(span_board.buf_size);
                else count = FIELD_W'($urandom_range(1, span_board.buf_size + 1));
                send_request(kind, count);
            end
            req_ch.valid <= 1'b0;
        end

        wait_for_drain();
        if (span_board.mismatches == 0 && span_board.expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* ring_buffer_span_manager.f */
hw/rtl/rbsm_pkg.sv
hw/rtl/rbsm_req_if.sv
hw/rtl/rbsm_rsp_if.sv
hw/rtl/rbsm_core.sv
hw/rtl/ring_buffer_span_manager.sv
hw/rtl/rbsm_checker.sv
tb/ring_buffer_span_manager_tb.sv
